/* hw/rtl/crafb_pkg.sv */
// Package: item types, frame constants and register map for the CAN record frame builder.
`timescale 1ns / 1ps

package crafb_pkg;

    // One logged CAN record
    typedef struct packed {
        logic [31:0] timestamp;
        logic [31:0] can_ident;
        logic [63:0] can_payload;
    } in_item_t;

    // One frame byte
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } out_item_t;

    // Frame layout
    localparam int FRAME_BYTES   = 35;
    localparam int PAYLOAD_BYTES = 17;
    localparam int CNT_W         = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] SUM_FIRST_IDX = CNT_W'(3);

    localparam logic [7:0] DELIMITER  = 8'h7E;
    localparam logic [7:0] LENGTH_HI  = 8'h00;
    localparam logic [7:0] LENGTH_LO  = 8'(14 + PAYLOAD_BYTES);
    localparam logic [7:0] FRAME_TYPE = 8'h10;

    // Register map (index = byte address / 8)
    localparam int ADDR_W = 6;
    localparam logic [2:0] REG_DEST_ADDRESS     = 3'd0;
    localparam logic [2:0] REG_SHORT_ADDRESS    = 3'd1;
    localparam logic [2:0] REG_FRAME_ID         = 3'd2;
    localparam logic [2:0] REG_BROADCAST_RADIUS = 3'd3;
    localparam logic [2:0] REG_TX_OPTIONS       = 3'd4;

    // Reset values
    localparam logic [63:0] DEST_ADDRESS_RST     = 64'h0013_A200_41C2_690F;
    localparam logic [15:0] SHORT_ADDRESS_RST    = 16'hFFFE;
    localparam logic [7:0]  FRAME_ID_RST         = 8'h01;
    localparam logic [7:0]  BROADCAST_RADIUS_RST = 8'h00;
    localparam logic [7:0]  TX_OPTIONS_RST       = 8'h00;

endpackage

/* hw/rtl/can_record_api_frame_builder_unit.sv */
// Top level: builds a 35-byte API transmit-request frame from each logged CAN record.
// Item path: input holding register, then byte sequencer, then output register.
// One frame byte per cycle out of the byte sequencer unless the output stalls.
// A second item is held in the input register while a frame is being sent.
// Reset (aresetn low at a clock edge): channels empty, configuration at reset values.
`timescale 1ns / 1ps

module can_record_api_frame_builder_unit
    import crafb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,

    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    // Configuration registers
    logic [63:0] dest_address_reg;
    logic [15:0] short_address_reg;
    logic [7:0]  frame_id_reg;
    logic [7:0]  broadcast_radius_reg;
    logic [7:0]  tx_options_reg;

    logic [2:0]  reg_idx;
    logic        cfg_write;

    // Input holding register
    logic        hold_valid_reg;
    in_item_t    hold_reg;

    // Byte sequencer
    logic             gen_valid_reg;
    in_item_t         rec_reg;
    logic [7:0]       xor_reg;
    logic [7:0]       sum_reg;
    logic [CNT_W-1:0] cnt_reg;

    // Output register
    logic        out_valid_reg;
    out_item_t   out_reg;

    logic        issue;
    logic        last_byte;
    logic        gen_load;
    logic [7:0]  byte_sel;
    logic [7:0]  xor_next;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite;

    // Register read-back
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_DEST_ADDRESS:     prdata = dest_address_reg;
            REG_SHORT_ADDRESS:    prdata = {48'd0, short_address_reg};
            REG_FRAME_ID:         prdata = {56'd0, frame_id_reg};
            REG_BROADCAST_RADIUS: prdata = {56'd0, broadcast_radius_reg};
            REG_TX_OPTIONS:       prdata = {56'd0, tx_options_reg};
            default:              prdata = '0;
        endcase
    end

    // Register writes; unmapped addresses are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_address_reg     <= DEST_ADDRESS_RST;
            short_address_reg    <= SHORT_ADDRESS_RST;
            frame_id_reg         <= FRAME_ID_RST;
            broadcast_radius_reg <= BROADCAST_RADIUS_RST;
            tx_options_reg       <= TX_OPTIONS_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_DEST_ADDRESS:     dest_address_reg     <= pwdata;
                REG_SHORT_ADDRESS:    short_address_reg    <= pwdata[15:0];
                REG_FRAME_ID:         frame_id_reg         <= pwdata[7:0];
                REG_BROADCAST_RADIUS: broadcast_radius_reg <= pwdata[7:0];
                REG_TX_OPTIONS:       tx_options_reg       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Handshake and sequencing control
    assign s_ready   = !hold_valid_reg;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign issue     = gen_valid_reg && (!out_valid_reg || m_ready);
    assign last_byte = (cnt_reg == LAST_IDX);
    assign gen_load  = hold_valid_reg && (!gen_valid_reg || (issue && last_byte));

    // XOR of the 16 record bytes, taken when the record enters the sequencer
    always_comb begin
        xor_next = '0;
        for (int i = 0; i < 4; i++) begin
            xor_next = xor_next ^ hold_reg.timestamp[8*i +: 8] ^ hold_reg.can_ident[8*i +: 8];
        end
        for (int i = 0; i < 8; i++) begin
            xor_next = xor_next ^ hold_reg.can_payload[8*i +: 8];
        end
    end

    // Frame byte for the current position
    always_comb begin
        byte_sel = '0;
        unique case (cnt_reg)
            6'd0:  byte_sel = DELIMITER;
            6'd1:  byte_sel = LENGTH_HI;
            6'd2:  byte_sel = LENGTH_LO;
            6'd3:  byte_sel = FRAME_TYPE;
            6'd4:  byte_sel = frame_id_reg;
            6'd5:  byte_sel = dest_address_reg[63:56];
            6'd6:  byte_sel = dest_address_reg[55:48];
            6'd7:  byte_sel = dest_address_reg[47:40];
            6'd8:  byte_sel = dest_address_reg[39:32];
            6'd9:  byte_sel = dest_address_reg[31:24];
            6'd10: byte_sel = dest_address_reg[23:16];
            6'd11: byte_sel = dest_address_reg[15:8];
            6'd12: byte_sel = dest_address_reg[7:0];
            6'd13: byte_sel = short_address_reg[15:8];
            6'd14: byte_sel = short_address_reg[7:0];
            6'd15: byte_sel = broadcast_radius_reg;
            6'd16: byte_sel = tx_options_reg;
            6'd17: byte_sel = rec_reg.timestamp[31:24];
            6'd18: byte_sel = rec_reg.timestamp[23:16];
            6'd19: byte_sel = rec_reg.timestamp[15:8];
            6'd20: byte_sel = rec_reg.timestamp[7:0];
            6'd21: byte_sel = rec_reg.can_ident[31:24];
            6'd22: byte_sel = rec_reg.can_ident[23:16];
            6'd23: byte_sel = rec_reg.can_ident[15:8];
            6'd24: byte_sel = rec_reg.can_ident[7:0];
            6'd25: byte_sel = rec_reg.can_payload[63:56];
            6'd26: byte_sel = rec_reg.can_payload[55:48];
            6'd27: byte_sel = rec_reg.can_payload[47:40];
            6'd28: byte_sel = rec_reg.can_payload[39:32];
            6'd29: byte_sel = rec_reg.can_payload[31:24];
            6'd30: byte_sel = rec_reg.can_payload[23:16];
            6'd31: byte_sel = rec_reg.can_payload[15:8];
            6'd32: byte_sel = rec_reg.can_payload[7:0];
            6'd33: byte_sel = xor_reg;
            6'd34: byte_sel = ~sum_reg;     // 0xFF minus the running sum
            default: byte_sel = '0;
        endcase
    end

    // Input holding register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            hold_valid_reg <= 1'b1;
        end else if (gen_load) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_reg <= s_data;
        end
    end

    // Byte sequencer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else if (gen_load) begin
            gen_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end else if (issue) begin
            if (last_byte) begin
                gen_valid_reg <= 1'b0;
                cnt_reg       <= '0;
            end else begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Record, XOR and running checksum sum
    always_ff @(posedge aclk) begin
        if (gen_load) begin
            rec_reg <= hold_reg;
            xor_reg <= xor_next;
            sum_reg <= '0;
        end else if (issue && (cnt_reg >= SUM_FIRST_IDX) && !last_byte) begin
            sum_reg <= sum_reg + byte_sel;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (issue) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            out_reg.out_byte  <= byte_sel;
            out_reg.frame_end <= last_byte;
        end
    end

endmodule
